// ===== rtl/bfp_pkg.sv =====
`default_nettype none
package bfp_pkg;

   localparam int SSID_MAX      = 32;
   localparam int MAX_FRAME_LEN = 2048;
   localparam int NUM_RESULTS   = SSID_MAX;
   localparam int IDX_W         = $clog2(NUM_RESULTS);
   localparam int POS_W         = $clog2(MAX_FRAME_LEN + 1);
   localparam int OFF_W         = $clog2(MAX_FRAME_LEN + 256 + 2);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam int FIRST_ELEM  = 36;
   localparam int MAC_FIRST   = 10;
   localparam int MAC_LAST    = 15;

   localparam logic [7:0] TAG_SSID    = 8'h00;
   localparam logic [7:0] TAG_CHANNEL = 8'h03;

   typedef struct packed {
      logic [47:0]                      mac;
      logic [7:0]                       channel;
      logic [7:0]                       ssid_size;
      logic                             error;
      logic [7:0]                       strength;
      logic [NUM_RESULTS-1:0][7:0]      ssid;
   } frame_summary_type;

endpackage
`default_nettype wire

// ===== rtl/bfp_front.sv =====
`default_nettype none
module bfp_front (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         accept,
   input  wire [7:0]                   frame_byte,
   input  wire                         last_byte,
   input  wire [7:0]                   signal_dbm,
   output logic                        push,
   output bfp_pkg::frame_summary_type  summary
);
   import bfp_pkg::*;

   logic [POS_W-1:0]              pos_ff, pos_in;
   logic [OFF_W-1:0]              next_off_ff, next_off_in;
   logic [POS_W-1:0]              elem_start_ff, elem_start_in;
   logic [7:0]                    tag_ff, tag_in;
   logic                          done_ff, done_in;
   logic                          err_ff, err_in;
   logic                          copy_ff, copy_in;
   logic [7:0]                    ssid_size_ff, ssid_size_in;
   logic [7:0]                    chan_ff, chan_in;
   logic [47:0]                   mac_ff, mac_in;
   logic [7:0]                    strength_ff, strength_in;
   logic [NUM_RESULTS-1:0][7:0]   ssid_ff, ssid_in;

   logic [OFF_W-1:0]              pos_ext;
   logic [OFF_W-1:0]              start_ext;
   logic [OFF_W-1:0]              data_off;
   logic                          tag_hit;

   assign pos_ext   = OFF_W'(pos_ff);
   assign start_ext = OFF_W'(elem_start_ff);
   assign data_off  = pos_ext - start_ext - OFF_W'(2);

   always_comb begin
      pos_in        = pos_ff;
      next_off_in   = next_off_ff;
      elem_start_in = elem_start_ff;
      tag_in        = tag_ff;
      done_in       = done_ff;
      err_in        = err_ff;
      copy_in       = copy_ff;
      ssid_size_in  = ssid_size_ff;
      chan_in       = chan_ff;
      mac_in        = mac_ff;
      strength_in   = strength_ff;
      ssid_in       = ssid_ff;
      tag_hit       = 1'b0;
      push          = 1'b0;

      if (accept) begin
         if (pos_ff == '0) begin
            strength_in = signal_dbm;
         end
         if (pos_ff < POS_W'(MAX_FRAME_LEN)) begin
            pos_in = pos_ff + POS_W'(1);
            if (pos_ff >= POS_W'(MAC_FIRST) && pos_ff <= POS_W'(MAC_LAST)) begin
               mac_in = {mac_ff[39:0], frame_byte};
            end
            if (!done_ff) begin
               priority if (pos_ext == next_off_ff) begin
                  if (pos_ff == POS_W'(FIRST_ELEM) && frame_byte != TAG_SSID) begin
                     err_in  = 1'b1;
                     done_in = 1'b1;
                  end else begin
                     tag_hit       = 1'b1;
                     tag_in        = frame_byte;
                     elem_start_in = pos_ff;
                     copy_in       = 1'b0;
                  end
               end else if (pos_ext == start_ext + OFF_W'(1) && next_off_ff == start_ext) begin
                  next_off_in = start_ext + OFF_W'(frame_byte) + OFF_W'(2);
                  if (tag_ff == TAG_SSID) begin
                     ssid_size_in = frame_byte;
                     copy_in      = 1'b0;
                     if (frame_byte == 8'd0) begin
                        ssid_in = '0;
                     end else if (frame_byte > 8'(SSID_MAX)) begin
                        err_in = 1'b1;
                     end else begin
                        ssid_in = '0;
                        err_in  = 1'b0;
                        copy_in = 1'b1;
                     end
                  end
               end else if (next_off_ff == start_ext || pos_ext < start_ext + OFF_W'(2)) begin
                  // waiting for length or inside element header
               end else if (tag_ff == TAG_CHANNEL && pos_ext == start_ext + OFF_W'(2)) begin
                  chan_in = frame_byte;
                  done_in = 1'b1;
               end else if (tag_ff == TAG_SSID && copy_ff && pos_ext < next_off_ff) begin
                  ssid_in[data_off[IDX_W-1:0]] = frame_byte;
               end
            end
         end

         if (last_byte) begin
            push              = 1'b1;
            summary.mac       = mac_in;
            summary.channel   = chan_in;
            summary.ssid_size = ssid_size_in;
            summary.error     = err_in;
            summary.strength  = strength_in;
            summary.ssid      = ssid_in;
            // frame cut right after an SSID tag: length reads as zero
            if (tag_hit && frame_byte == TAG_SSID) begin
               summary.ssid_size = '0;
               summary.ssid      = '0;
            end
            pos_in        = '0;
            next_off_in   = OFF_W'(FIRST_ELEM);
            elem_start_in = '0;
            tag_in        = '0;
            done_in       = 1'b0;
            err_in        = 1'b0;
            copy_in       = 1'b0;
            ssid_size_in  = '0;
            chan_in       = '0;
            mac_in        = '0;
            strength_in   = '0;
            ssid_in       = '0;
         end else begin
            summary = '0;
         end
      end else begin
         summary = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         next_off_ff   <= OFF_W'(FIRST_ELEM);
         elem_start_ff <= '0;
         tag_ff        <= '0;
         done_ff       <= 1'b0;
         err_ff        <= 1'b0;
         copy_ff       <= 1'b0;
         ssid_size_ff  <= '0;
         chan_ff       <= '0;
         mac_ff        <= '0;
         strength_ff   <= '0;
         ssid_ff       <= '0;
      end else begin
         pos_ff        <= pos_in;
         next_off_ff   <= next_off_in;
         elem_start_ff <= elem_start_in;
         tag_ff        <= tag_in;
         done_ff       <= done_in;
         err_ff        <= err_in;
         copy_ff       <= copy_in;
         ssid_size_ff  <= ssid_size_in;
         chan_ff       <= chan_in;
         mac_ff        <= mac_in;
         strength_ff   <= strength_in;
         ssid_ff       <= ssid_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/bfp_queue.sv =====
`default_nettype none
module bfp_queue (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         push,
   input  bfp_pkg::frame_summary_type  push_data,
   input  wire                         pop,
   output bfp_pkg::frame_summary_type  head,
   output logic                        full,
   output logic                        empty
);
   import bfp_pkg::*;

   frame_summary_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]          wr_ff, wr_in;
   logic [QPTR_W-1:0]          rd_ff, rd_in;
   logic [QCNT_W-1:0]          cnt_ff, cnt_in;
   logic                       do_push;
   logic                       do_pop;

   assign full    = cnt_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty   = cnt_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/bfp_back.sv =====
`default_nettype none
module bfp_back (
   input  wire                         clock,
   input  wire                         reset,
   input  bfp_pkg::frame_summary_type  head,
   input  wire                         empty,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output logic [47:0]                 rsp_source_mac,
   output logic [7:0]                  rsp_channel_number,
   output logic [7:0]                  rsp_ssid_length,
   output logic                        rsp_parse_error,
   output logic signed [8:0]           rsp_strength_negated,
   output logic [7:0]                  rsp_ssid_char,
   output logic [bfp_pkg::IDX_W-1:0]   rsp_ssid_position,
   output logic                        rsp_final_result
);
   import bfp_pkg::*;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             take;
   logic             last_idx;

   assign rsp_valid = !empty;
   assign take      = rsp_valid && rsp_ready;
   assign last_idx  = idx_ff == IDX_W'(NUM_RESULTS - 1);
   assign pop       = take && last_idx;

   assign rsp_source_mac       = head.mac;
   assign rsp_channel_number   = head.channel;
   assign rsp_ssid_length      = head.ssid_size;
   assign rsp_parse_error      = head.error;
   assign rsp_strength_negated = 9'sd0 - $signed({head.strength[7], head.strength});
   assign rsp_ssid_char        = head.ssid[idx_ff];
   assign rsp_ssid_position    = idx_ff;
   assign rsp_final_result     = last_idx;

   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = last_idx ? '0 : idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/beacon_frame_ie_parser.sv =====
`default_nettype none
// Beacon element parser. Frame bytes are taken at one per cycle with no gaps
// needed; the parser never stalls inside a frame on its own. On the byte marked
// last, the frame summary and SSID are placed into a two-entry frame queue and
// the parser is ready for the next frame in the following cycle unless the queue
// is then full. Each queued frame is played out as 32 result items, one per cycle
// while rsp_ready is high, SSID position 0 first. The input stalls only when two
// finished frames are waiting, so back-to-back frames shorter than 32 bytes are
// paced by the result side. No clearing pass after reset.
module beacon_frame_ie_parser (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire [7:0]                  req_frame_byte,
   input  wire                        req_last_byte,
   input  wire signed [7:0]           req_signal_dbm,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output logic [47:0]                rsp_source_mac,
   output logic [7:0]                 rsp_channel_number,
   output logic [7:0]                 rsp_ssid_length,
   output logic                       rsp_parse_error,
   output logic signed [8:0]          rsp_strength_negated,
   output logic [7:0]                 rsp_ssid_char,
   output logic [bfp_pkg::IDX_W-1:0]  rsp_ssid_position,
   output logic                       rsp_final_result
);
   import bfp_pkg::*;

   frame_summary_type push_data;
   frame_summary_type head;
   logic              push;
   logic              pop;
   logic              q_full;
   logic              q_empty;
   logic              req_take;

   assign req_ready = !q_full;
   assign req_take  = req_valid && req_ready;

   bfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_take),
      .frame_byte (req_frame_byte),
      .last_byte  (req_last_byte),
      .signal_dbm (req_signal_dbm),
      .push       (push),
      .summary    (push_data)
   );

   bfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .full      (q_full),
      .empty     (q_empty)
   );

   bfp_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head                 (head),
      .empty                (q_empty),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_source_mac       (rsp_source_mac),
      .rsp_channel_number   (rsp_channel_number),
      .rsp_ssid_length      (rsp_ssid_length),
      .rsp_parse_error      (rsp_parse_error),
      .rsp_strength_negated (rsp_strength_negated),
      .rsp_ssid_char        (rsp_ssid_char),
      .rsp_ssid_position    (rsp_ssid_position),
      .rsp_final_result     (rsp_final_result)
   );

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_full))
      else $error("frame queue overflow");

   a_restart_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_final_result) |=> (rsp_ssid_position == '0))
      else $error("result index did not restart after final item");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_pop_on_final: assert property (@(posedge clock) disable iff (reset)
      pop |-> (rsp_final_result && rsp_valid && rsp_ready))
      else $error("frame retired before its last item");
`endif

endmodule
`default_nettype wire
